FILE: design/gps_pkg.sv
// Shared types, constants and fixed-point helpers of the Gaussian elimination solver.
package gps_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int MAX_ORDER  = 8;
  localparam int WIDE_WIDTH = DATA_WIDTH + FRAC_BITS;
  localparam int ADDR_WIDTH = 7;

  localparam logic [1:0] FUNC_LOAD_A = 2'd0;
  localparam logic [1:0] FUNC_LOAD_B = 2'd1;
  localparam logic [1:0] FUNC_SOLVE  = 2'd2;

  localparam logic REG_SIZE   = 1'b0;
  localparam logic REG_THRESH = 1'b1;

  localparam logic [3:0] RHS_COL = 4'd8;

  localparam logic signed [DATA_WIDTH-1:0] WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic [1:0]                   func;
    logic [2:0]                   row;
    logic [2:0]                   col;
    logic signed [DATA_WIDTH-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] solution;
    logic [2:0]                   index;
    logic                         status;
    logic                         last;
  } out_item_t;

  typedef enum logic {
    OP_MULSUB,
    OP_DIV
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  function automatic logic [DATA_WIDTH-1:0] mag_of(input logic signed [DATA_WIDTH-1:0] v);
    logic [DATA_WIDTH-1:0] u;
    u = v;
    return v[DATA_WIDTH-1] ? (~u + 1'b1) : u;
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] sat_mag(input logic [WIDE_WIDTH-1:0] m,
                                                           input logic neg);
    logic [WIDE_WIDTH-1:0] lim;
    logic [WIDE_WIDTH-1:0] c;
    logic [DATA_WIDTH-1:0] w;
    lim = neg ? {{(WIDE_WIDTH-DATA_WIDTH){1'b0}}, WORD_MIN}
              : {{(WIDE_WIDTH-DATA_WIDTH){1'b0}}, WORD_MAX};
    c = (m > lim) ? lim : m;
    w = c[DATA_WIDTH-1:0];
    return neg ? (~w + 1'b1) : w;
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] sub_sat(input logic signed [DATA_WIDTH-1:0] a,
                                                           input logic signed [DATA_WIDTH-1:0] b);
    logic signed [DATA_WIDTH:0] d;
    d = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
    if (d[DATA_WIDTH] != d[DATA_WIDTH-1]) begin
      return d[DATA_WIDTH] ? WORD_MIN : WORD_MAX;
    end
    return d[DATA_WIDTH-1:0];
  endfunction

endpackage

FILE: design/gps_alu.sv
// Shared multi-cycle fixed-point unit: saturating multiply-subtract and division.
module gps_alu (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  gps_pkg::alu_req_t                     req,
  input  logic signed [gps_pkg::DATA_WIDTH-1:0] a,
  input  logic signed [gps_pkg::DATA_WIDTH-1:0] x,
  input  logic signed [gps_pkg::DATA_WIDTH-1:0] y,
  output logic                                  done,
  output logic signed [gps_pkg::DATA_WIDTH-1:0] res
);
  import gps_pkg::*;

  typedef enum logic [2:0] {
    A_IDLE, A_MUL, A_MSAT, A_MSUB, A_DIV, A_DFIN
  } alu_state_t;

  alu_state_t                    state_r;
  logic                          done_r;
  logic signed [DATA_WIDTH-1:0]  res_r;
  logic signed [DATA_WIDTH-1:0]  a_r;
  logic [DATA_WIDTH-1:0]         xm_r;
  logic [DATA_WIDTH-1:0]         ym_r;
  logic                          mneg_r;
  logic                          dneg_r;
  logic [2*DATA_WIDTH-1:0]       prod_r;
  logic signed [DATA_WIDTH-1:0]  p_r;
  logic [WIDE_WIDTH-1:0]         num_r;
  logic [WIDE_WIDTH-1:0]         q_r;
  logic [DATA_WIDTH-1:0]         rem_r;
  logic [5:0]                    cnt_r;
  logic [DATA_WIDTH:0]           rem_nxt;
  logic [DATA_WIDTH-1:0]         am;
  logic [DATA_WIDTH-1:0]         ymag;

  assign am      = mag_of(a);
  assign ymag    = mag_of(y);
  assign rem_nxt = {rem_r, num_r[WIDE_WIDTH-1]};
  assign done    = done_r;
  assign res     = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        A_IDLE: begin
          if (req.start) begin
            a_r    <= a;
            xm_r   <= mag_of(x);
            ym_r   <= ymag;
            mneg_r <= x[DATA_WIDTH-1] ^ y[DATA_WIDTH-1];
            dneg_r <= a[DATA_WIDTH-1] ^ y[DATA_WIDTH-1];
            if (req.op == OP_MULSUB) begin
              state_r <= A_MUL;
            end else if (ymag == '0) begin
              res_r  <= (am == '0) ? '0 : (a[DATA_WIDTH-1] ? WORD_MIN : WORD_MAX);
              done_r <= 1'b1;
            end else begin
              num_r   <= {am, {FRAC_BITS{1'b0}}};
              rem_r   <= '0;
              q_r     <= '0;
              cnt_r   <= 6'(WIDE_WIDTH - 1);
              state_r <= A_DIV;
            end
          end
        end
        A_MUL: begin
          prod_r  <= xm_r * ym_r;
          state_r <= A_MSAT;
        end
        A_MSAT: begin
          p_r     <= sat_mag(prod_r[2*DATA_WIDTH-1:FRAC_BITS], mneg_r);
          state_r <= A_MSUB;
        end
        A_MSUB: begin
          res_r   <= sub_sat(a_r, p_r);
          done_r  <= 1'b1;
          state_r <= A_IDLE;
        end
        A_DIV: begin
          if (rem_nxt >= {1'b0, ym_r}) begin
            rem_r <= DATA_WIDTH'(rem_nxt - {1'b0, ym_r});
            q_r   <= {q_r[WIDE_WIDTH-2:0], 1'b1};
          end else begin
            rem_r <= rem_nxt[DATA_WIDTH-1:0];
            q_r   <= {q_r[WIDE_WIDTH-2:0], 1'b0};
          end
          num_r <= {num_r[WIDE_WIDTH-2:0], 1'b0};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= A_DFIN;
          end
        end
        A_DFIN: begin
          res_r   <= sat_mag(q_r, dneg_r);
          done_r  <= 1'b1;
          state_r <= A_IDLE;
        end
        default: state_r <= A_IDLE;
      endcase
    end
  end

endmodule

FILE: design/gauss_pivot_linear_solver_core.sv
// Top level of the Gaussian elimination solver with partial pivoting, signed Q16.16.
//
// Load beats (matrix entry or right-hand-side entry) are taken one per cycle while busy is
// low. A solve beat holds busy high for the whole solve: a copy of the entry store into the
// working memory, then for each column a pivot search, a row swap where the pivot row
// differs, a division in the shared unit per row below and a multiply-subtract per updated
// entry; back substitution uses the same unit for each product and divisor. The shared
// arithmetic unit, its 48-step divider and the single read port of the working memory set
// the length of a solve. Results leave on a one-cycle strobe and cannot be held off; a
// singular system gives one result only.
module gauss_pivot_linear_solver_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  gps_pkg::in_item_t     in_item,
  output logic                  out_valid,
  output gps_pkg::out_item_t    out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [31:0]           cfg_data
);
  import gps_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_COPY, S_PIV, S_PCHK, S_SW_RA, S_SW_RB, S_SW_WK, S_SW_WP,
    S_EL_START, S_EL_PV, S_EL_ROW, S_EL_F, S_EL_FW, S_EL_COL, S_EL_RB, S_EL_RA,
    S_EL_WAIT, S_BK_ROW, S_BK_ACC, S_BK_COL, S_BK_RA, S_BK_RB, S_BK_WAIT,
    S_BK_DIV, S_BK_DW, S_OUT, S_OUT_W
  } state_t;

  state_t                        state_r;
  logic                          out_valid_r;
  out_item_t                     out_item_r;
  logic [3:0]                    size_r;
  logic [DATA_WIDTH-2:0]         thresh_r;
  logic [7:0]                    cnt_r;
  logic [3:0]                    k_r;
  logic [3:0]                    i_r;
  logic [3:0]                    j_r;
  logic [3:0]                    p_r;
  logic                          rv_r;
  logic [3:0]                    rtag_r;
  logic [DATA_WIDTH-1:0]         best_r;
  logic signed [DATA_WIDTH-1:0]  t_r;
  logic signed [DATA_WIDTH-1:0]  pv_r;
  logic signed [DATA_WIDTH-1:0]  f_r;
  logic signed [DATA_WIDTH-1:0]  b_r;
  logic signed [DATA_WIDTH-1:0]  acc_r;
  logic signed [DATA_WIDTH-1:0]  x_r;

  logic signed [DATA_WIDTH-1:0]  store_mem [2**ADDR_WIDTH];
  logic signed [DATA_WIDTH-1:0]  work_mem  [2**ADDR_WIDTH];
  logic signed [DATA_WIDTH-1:0]  st_q;
  logic signed [DATA_WIDTH-1:0]  wm_q;

  logic                          st_we;
  logic [ADDR_WIDTH-1:0]         st_waddr;
  logic [ADDR_WIDTH-1:0]         wm_raddr;
  logic                          wm_we;
  logic [ADDR_WIDTH-1:0]         wm_waddr;
  logic signed [DATA_WIDTH-1:0]  wm_wdata;

  alu_req_t                      alu_req;
  logic signed [DATA_WIDTH-1:0]  alu_a;
  logic signed [DATA_WIDTH-1:0]  alu_x;
  logic signed [DATA_WIDTH-1:0]  alu_y;
  logic                          alu_done;
  logic signed [DATA_WIDTH-1:0]  alu_res;

  logic [3:0]                    n;
  logic [DATA_WIDTH-1:0]         m;
  logic [3:0]                    first_col;
  logic [3:0]                    next_col;
  logic                          accept;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign accept    = start && !busy;

  assign n         = (size_r == 4'd0) ? 4'd1 :
                     ((size_r > 4'(MAX_ORDER)) ? 4'(MAX_ORDER) : size_r);
  assign m         = mag_of(wm_q);
  assign first_col = (k_r + 4'd1 < n) ? (k_r + 4'd1) : RHS_COL;
  assign next_col  = (j_r + 4'd1 < n) ? (j_r + 4'd1) : RHS_COL;

  assign st_we    = accept && (in_item.func == FUNC_LOAD_A || in_item.func == FUNC_LOAD_B);
  assign st_waddr = (in_item.func == FUNC_LOAD_A) ? {in_item.row, 1'b0, in_item.col}
                                                  : {in_item.row, RHS_COL};

  always_ff @(posedge clk) begin
    if (st_we) begin
      store_mem[st_waddr] <= in_item.value;
    end
    st_q <= store_mem[cnt_r[ADDR_WIDTH-1:0]];
  end

  always_ff @(posedge clk) begin
    if (wm_we) begin
      work_mem[wm_waddr] <= wm_wdata;
    end
    wm_q <= work_mem[wm_raddr];
  end

  always_comb begin
    wm_raddr      = '0;
    wm_we         = 1'b0;
    wm_waddr      = '0;
    wm_wdata      = wm_q;
    alu_req.start = 1'b0;
    alu_req.op    = OP_MULSUB;
    alu_a         = wm_q;
    alu_x         = f_r;
    alu_y         = b_r;
    unique case (state_r)
      S_COPY: begin
        wm_we    = (cnt_r != 8'd0);
        wm_waddr = ADDR_WIDTH'(cnt_r - 8'd1);
        wm_wdata = st_q;
      end
      S_PIV:      wm_raddr = {i_r[2:0], 1'b0, k_r[2:0]};
      S_SW_RA:    wm_raddr = {k_r[2:0], j_r};
      S_SW_RB:    wm_raddr = {p_r[2:0], j_r};
      S_SW_WK: begin
        wm_we    = 1'b1;
        wm_waddr = {k_r[2:0], j_r};
        wm_wdata = wm_q;
      end
      S_SW_WP: begin
        wm_we    = 1'b1;
        wm_waddr = {p_r[2:0], j_r};
        wm_wdata = t_r;
      end
      S_EL_START: wm_raddr = {k_r[2:0], 1'b0, k_r[2:0]};
      S_EL_ROW:   wm_raddr = {i_r[2:0], 1'b0, k_r[2:0]};
      S_EL_F: begin
        alu_req.start = 1'b1;
        alu_req.op    = OP_DIV;
        alu_y         = pv_r;
      end
      S_EL_COL:   wm_raddr = {k_r[2:0], j_r};
      S_EL_RB:    wm_raddr = {i_r[2:0], j_r};
      S_EL_RA:    alu_req.start = 1'b1;
      S_EL_WAIT: begin
        wm_we    = alu_done;
        wm_waddr = {i_r[2:0], j_r};
        wm_wdata = alu_res;
      end
      S_BK_ROW:   wm_raddr = {i_r[2:0], RHS_COL};
      S_BK_COL:   wm_raddr = (j_r < n) ? {i_r[2:0], j_r} : {i_r[2:0], 1'b0, i_r[2:0]};
      S_BK_RA:    wm_raddr = {j_r[2:0], RHS_COL};
      S_BK_RB: begin
        alu_req.start = 1'b1;
        alu_a         = acc_r;
        alu_x         = x_r;
        alu_y         = wm_q;
      end
      S_BK_DIV: begin
        alu_req.start = 1'b1;
        alu_req.op    = OP_DIV;
        alu_a         = acc_r;
        alu_y         = wm_q;
      end
      S_BK_DW: begin
        wm_we    = alu_done;
        wm_waddr = {i_r[2:0], RHS_COL};
        wm_wdata = alu_res;
      end
      S_OUT:      wm_raddr = {i_r[2:0], RHS_COL};
      default: ;
    endcase
  end

  gps_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .a     (alu_a),
    .x     (alu_x),
    .y     (alu_y),
    .done  (alu_done),
    .res   (alu_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      size_r      <= 4'd8;
      thresh_r    <= (DATA_WIDTH-1)'(1);
      rv_r        <= 1'b0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SIZE) begin
          size_r <= cfg_data[3:0];
        end else begin
          thresh_r <= cfg_data[DATA_WIDTH-2:0];
        end
      end
      unique case (state_r)
        S_IDLE: begin
          cnt_r <= '0;
          if (accept && in_item.func == FUNC_SOLVE) begin
            state_r <= S_COPY;
          end
        end
        S_COPY: begin
          cnt_r <= cnt_r + 8'd1;
          if (cnt_r == 8'(2**ADDR_WIDTH)) begin
            k_r     <= '0;
            i_r     <= '0;
            rv_r    <= 1'b0;
            state_r <= S_PIV;
          end
        end
        S_PIV: begin
          if (i_r < n) begin
            rv_r   <= 1'b1;
            rtag_r <= i_r;
            i_r    <= i_r + 4'd1;
          end else begin
            rv_r <= 1'b0;
          end
          if (rv_r && (rtag_r == k_r || m > best_r)) begin
            best_r <= m;
            p_r    <= rtag_r;
          end
          if (rv_r && i_r >= n) begin
            state_r <= S_PCHK;
          end
        end
        S_PCHK: begin
          j_r <= '0;
          i_r <= k_r + 4'd1;
          if (best_r < {1'b0, thresh_r}) begin
            out_valid_r         <= 1'b1;
            out_item_r.solution <= '0;
            out_item_r.index    <= '0;
            out_item_r.status   <= 1'b1;
            out_item_r.last     <= 1'b1;
            state_r             <= S_IDLE;
          end else if (p_r != k_r) begin
            state_r <= S_SW_RA;
          end else begin
            state_r <= S_EL_START;
          end
        end
        S_SW_RA: state_r <= S_SW_RB;
        S_SW_RB: begin
          t_r     <= wm_q;
          state_r <= S_SW_WK;
        end
        S_SW_WK: state_r <= S_SW_WP;
        S_SW_WP: begin
          if (j_r == RHS_COL) begin
            state_r <= S_EL_START;
          end else begin
            j_r     <= j_r + 4'd1;
            state_r <= S_SW_RA;
          end
        end
        S_EL_START: state_r <= S_EL_PV;
        S_EL_PV: begin
          pv_r    <= wm_q;
          state_r <= S_EL_ROW;
        end
        S_EL_ROW: begin
          if (i_r < n) begin
            state_r <= S_EL_F;
          end else if (k_r + 4'd1 == n) begin
            i_r     <= n - 4'd1;
            state_r <= S_BK_ROW;
          end else begin
            k_r     <= k_r + 4'd1;
            i_r     <= k_r + 4'd1;
            rv_r    <= 1'b0;
            state_r <= S_PIV;
          end
        end
        S_EL_F: state_r <= S_EL_FW;
        S_EL_FW: begin
          if (alu_done) begin
            f_r     <= alu_res;
            j_r     <= first_col;
            state_r <= S_EL_COL;
          end
        end
        S_EL_COL: state_r <= S_EL_RB;
        S_EL_RB: begin
          b_r     <= wm_q;
          state_r <= S_EL_RA;
        end
        S_EL_RA: state_r <= S_EL_WAIT;
        S_EL_WAIT: begin
          if (alu_done) begin
            if (j_r == RHS_COL) begin
              i_r     <= i_r + 4'd1;
              state_r <= S_EL_ROW;
            end else begin
              j_r     <= next_col;
              state_r <= S_EL_COL;
            end
          end
        end
        S_BK_ROW: state_r <= S_BK_ACC;
        S_BK_ACC: begin
          acc_r   <= wm_q;
          j_r     <= i_r + 4'd1;
          state_r <= S_BK_COL;
        end
        S_BK_COL: state_r <= (j_r < n) ? S_BK_RA : S_BK_DIV;
        S_BK_RA: begin
          x_r     <= wm_q;
          state_r <= S_BK_RB;
        end
        S_BK_RB: state_r <= S_BK_WAIT;
        S_BK_WAIT: begin
          if (alu_done) begin
            acc_r   <= alu_res;
            j_r     <= j_r + 4'd1;
            state_r <= S_BK_COL;
          end
        end
        S_BK_DIV: state_r <= S_BK_DW;
        S_BK_DW: begin
          if (alu_done) begin
            if (i_r == 4'd0) begin
              state_r <= S_OUT;
            end else begin
              i_r     <= i_r - 4'd1;
              state_r <= S_BK_ROW;
            end
          end
        end
        S_OUT: state_r <= S_OUT_W;
        S_OUT_W: begin
          out_valid_r         <= 1'b1;
          out_item_r.solution <= wm_q;
          out_item_r.index    <= i_r[2:0];
          out_item_r.status   <= 1'b0;
          out_item_r.last     <= (i_r + 4'd1 == n);
          if (i_r + 4'd1 == n) begin
            state_r <= S_IDLE;
          end else begin
            i_r     <= i_r + 4'd1;
            state_r <= S_OUT;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/gps_checker.sv
// Port-level checker for the solver core and its bind to the top level.
module gps_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input gps_pkg::in_item_t  in_item,
  input logic               out_valid,
  input gps_pkg::out_item_t out_item
);
  import gps_pkg::*;

  a_singular_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status |-> out_item.last)
    else $error("singular beat not marked last");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status |-> out_item.solution == '0 && out_item.index == '0)
    else $error("singular beat carries nonzero payload");

  a_solve_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.func == FUNC_SOLVE |=> busy)
    else $error("solve beat did not raise busy");

  a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |=> busy)
    else $error("solve ended before its last result");

endmodule

bind gauss_pivot_linear_solver_core gps_checker u_gps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);

FILE: tb/gauss_pivot_linear_solver_core_tb.sv
// Self-checking testbench of the Gaussian elimination solver with a built-in fixed-point predictor.
module gauss_pivot_linear_solver_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gps_pkg::*;

  localparam int STALL_LIMIT = 40000;
  localparam longint POS_SAT = 64'sd2147483647;
  localparam longint NEG_SAT = -64'sd2147483648;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_item_t in_item;
  logic out_valid;
  out_item_t out_item;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [31:0] cfg_data;

  gauss_pivot_linear_solver_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  longint mat_store [MAX_ORDER][MAX_ORDER];
  longint rhs_store [MAX_ORDER];
  bit mat_written [MAX_ORDER][MAX_ORDER];
  bit rhs_written [MAX_ORDER];
  int order_reg;
  longint thresh_reg;
  out_item_t pending_solutions[$];
  int errors;
  int beats_sent;
  bit quiet;
  int stall_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint saturate(bit neg, longint m);
    if (neg) begin
      return (m > 64'sd2147483648) ? NEG_SAT : -m;
    end
    return (m > POS_SAT) ? POS_SAT : m;
  endfunction

  function automatic longint fx_sub(longint a, longint b);
    longint d;
    d = a - b;
    if (d > POS_SAT) return POS_SAT;
    if (d < NEG_SAT) return NEG_SAT;
    return d;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return saturate((a < 0) != (b < 0), (magnitude(a) * magnitude(b)) >>> FRAC_BITS);
  endfunction

  function automatic longint fx_div(longint a, longint b);
    if (b == 0) begin
      if (a == 0) return 0;
      return (a < 0) ? NEG_SAT : POS_SAT;
    end
    return saturate((a < 0) != (b < 0), (magnitude(a) <<< FRAC_BITS) / magnitude(b));
  endfunction

  function automatic int effective_order();
    if (order_reg == 0) return 1;
    if (order_reg > MAX_ORDER) return MAX_ORDER;
    return order_reg;
  endfunction

  task automatic predict_solution();
    longint wa [MAX_ORDER][MAX_ORDER];
    longint wb [MAX_ORDER];
    longint best, m, t, f, acc;
    int n, p;
    out_item_t r;
    n = effective_order();
    wa = mat_store;
    wb = rhs_store;
    for (int k = 0; k < n; k++) begin
      p = k;
      best = magnitude(wa[k][k]);
      for (int i = k + 1; i < n; i++) begin
        m = magnitude(wa[i][k]);
        if (m > best) begin
          best = m;
          p = i;
        end
      end
      if (best < thresh_reg) begin
        r = '0;
        r.status = 1'b1;
        r.last = 1'b1;
        pending_solutions.push_back(r);
        return;
      end
      if (p != k) begin
        for (int j = 0; j < n; j++) begin
          t = wa[k][j];
          wa[k][j] = wa[p][j];
          wa[p][j] = t;
        end
        t = wb[k];
        wb[k] = wb[p];
        wb[p] = t;
      end
      for (int i = k + 1; i < n; i++) begin
        f = fx_div(wa[i][k], wa[k][k]);
        for (int j = k + 1; j < n; j++) wa[i][j] = fx_sub(wa[i][j], fx_mul(f, wa[k][j]));
        wb[i] = fx_sub(wb[i], fx_mul(f, wb[k]));
      end
    end
    for (int i = n - 1; i >= 0; i--) begin
      acc = wb[i];
      for (int j = i + 1; j < n; j++) acc = fx_sub(acc, fx_mul(wa[i][j], wb[j]));
      wb[i] = fx_div(acc, wa[i][i]);
    end
    for (int i = 0; i < n; i++) begin
      r.solution = wb[i][31:0];
      r.index = i[2:0];
      r.status = 1'b0;
      r.last = (i == n - 1);
      pending_solutions.push_back(r);
    end
  endtask

  task automatic send_beat(logic [1:0] func, int row, int col, logic signed [31:0] value);
    in_item_t it;
    if (!quiet && $urandom_range(0, 99) < 20) begin
      start <= 1'b0;
      @(posedge clk);
    end
    it.func = func;
    it.row = row[2:0];
    it.col = col[2:0];
    it.value = value;
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    beats_sent++;
    case (func)
      FUNC_LOAD_A: begin
        mat_store[row][col] = value;
        mat_written[row][col] = 1'b1;
      end
      FUNC_LOAD_B: begin
        rhs_store[row] = value;
        rhs_written[row] = 1'b1;
      end
      FUNC_SOLVE: predict_solution();
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_solutions.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_SIZE) order_reg = data[3:0];
    else thresh_reg = data[30:0];
  endtask

  function automatic logic signed [31:0] random_value(bit diag);
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return diag ? 32'sd0 : $signed($urandom_range(0, 32'h0001_0000)) - 32'sd32768;
      default: begin
        if (diag) return $signed($urandom_range(32'h0008_0000, 32'h0010_0000))
                         * ($urandom_range(0, 1) ? 1 : -1);
        return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      end
    endcase
  endfunction

  task automatic run_system();
    int n, cnt, pick, tmp;
    int slots [MAX_ORDER * MAX_ORDER + MAX_ORDER];
    n = effective_order();
    cnt = n * n + n;
    for (int s = 0; s < cnt; s++) slots[s] = s;
    for (int s = cnt - 1; s > 0; s--) begin
      pick = $urandom_range(0, s);
      tmp = slots[s];
      slots[s] = slots[pick];
      slots[pick] = tmp;
    end
    for (int s = 0; s < cnt; s++) begin
      if (slots[s] >= n * n) begin
        if (!rhs_written[slots[s] - n * n] || $urandom_range(0, 3) != 0)
          send_beat(FUNC_LOAD_B, slots[s] - n * n, 0, random_value(1'b0));
      end else if (!mat_written[slots[s] / n][slots[s] % n] || $urandom_range(0, 3) != 0) begin
        send_beat(FUNC_LOAD_A, slots[s] / n, slots[s] % n,
                  random_value(slots[s] / n == slots[s] % n));
      end
    end
    send_beat(FUNC_SOLVE, $urandom_range(0, 7), $urandom_range(0, 7), $urandom);
  endtask

  task automatic test_directed();
    write_reg(REG_SIZE, 32'd1);
    write_reg(REG_THRESH, 32'd1);
    send_beat(FUNC_LOAD_A, 0, 0, 32'sh0002_0000);
    send_beat(FUNC_LOAD_B, 0, 0, 32'sh0003_0000);
    send_beat(FUNC_SOLVE, 0, 0, 32'sd0);
    send_beat(FUNC_LOAD_A, 0, 0, WORD_MIN);
    send_beat(FUNC_LOAD_B, 0, 7, WORD_MAX);
    send_beat(FUNC_SOLVE, 7, 7, 32'hFFFF_FFFF);
    send_beat(2'd3, 7, 7, 32'hFFFF_FFFF);
    write_reg(REG_SIZE, 32'd2);
    send_beat(FUNC_LOAD_A, 0, 0, 32'sd0);
    send_beat(FUNC_LOAD_A, 0, 1, 32'sh0001_0000);
    send_beat(FUNC_LOAD_A, 1, 0, 32'sh0001_0000);
    send_beat(FUNC_LOAD_A, 1, 1, 32'sh0001_0000);
    send_beat(FUNC_LOAD_B, 1, 0, 32'sh0003_0000);
    send_beat(FUNC_SOLVE, 0, 0, 32'sd0);
    send_beat(FUNC_LOAD_A, 0, 0, -32'sh0001_0000);
    send_beat(FUNC_SOLVE, 0, 0, 32'sd0);
    send_beat(FUNC_LOAD_A, 0, 0, 32'sh0001_0000);
    send_beat(FUNC_SOLVE, 0, 0, 32'sd0);
    write_reg(REG_THRESH, 32'd0);
    send_beat(FUNC_SOLVE, 0, 0, 32'sd0);
    write_reg(REG_THRESH, 32'h7FFF_FFFF);
    send_beat(FUNC_SOLVE, 0, 0, 32'sd0);
    write_reg(REG_THRESH, 32'd1);
    write_reg(REG_SIZE, 32'd0);
    send_beat(FUNC_SOLVE, 0, 0, 32'sd0);
  endtask

  task automatic test_back_to_back();
    quiet = 1'b1;
    write_reg(REG_SIZE, 32'd3);
    run_system();
    run_system();
    quiet = 1'b0;
  endtask

  task automatic test_random();
    while (beats_sent < 200) begin
      case ($urandom_range(0, 9))
        0: begin
          case ($urandom_range(0, 5))
            0: write_reg(REG_SIZE, 32'd15);
            1: write_reg(REG_SIZE, $urandom_range(0, 15));
            default: write_reg(REG_SIZE, $urandom_range(1, 4));
          endcase
          case ($urandom_range(0, 5))
            0: write_reg(REG_THRESH, 32'd0);
            1: write_reg(REG_THRESH, 32'h7FFF_FFFF);
            2: write_reg(REG_THRESH, $urandom);
            3: write_reg(REG_THRESH, $urandom_range(0, 32'h0001_0000));
            default: write_reg(REG_THRESH, 32'd1);
          endcase
        end
        1: begin
          repeat ($urandom_range(1, 5)) begin
            send_beat($urandom_range(0, 1) ? 2'd3 : 2'($urandom_range(0, 1)),
                      $urandom_range(0, 7), $urandom_range(0, 7), $urandom);
          end
        end
        2: begin
          run_system();
          wait_idle();
        end
        default: run_system();
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_solutions.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $time, out_item);
        errors++;
      end else begin
        if (out_item.solution !== pending_solutions[0].solution) begin
          $display("%0t: solution expected %0d actual %0d", $time,
                   pending_solutions[0].solution, out_item.solution);
          errors++;
        end
        if (out_item.index !== pending_solutions[0].index) begin
          $display("%0t: index expected %0d actual %0d", $time,
                   pending_solutions[0].index, out_item.index);
          errors++;
        end
        if (out_item.status !== pending_solutions[0].status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   pending_solutions[0].status, out_item.status);
          errors++;
        end
        if (out_item.last !== pending_solutions[0].last) begin
          $display("%0t: last expected %0d actual %0d", $time,
                   pending_solutions[0].last, out_item.last);
          errors++;
        end
        void'(pending_solutions.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready) || !rst_n) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    beats_sent = 0;
    quiet = 1'b0;
    order_reg = MAX_ORDER;
    thresh_reg = 1;
    for (int r = 0; r < MAX_ORDER; r++) begin
      rhs_store[r] = 0;
      rhs_written[r] = 1'b0;
      for (int c = 0; c < MAX_ORDER; c++) begin
        mat_store[r][c] = 0;
        mat_written[r][c] = 1'b0;
      end
    end
    rst_n <= 1'b0;
    start <= 1'b0;
    in_item <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= 1'b0;
    cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_back_to_back();
    test_random();
    wait_idle();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
